@@ rtl/ssc_pkg.sv @@
`default_nettype none
package ssc_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h23;
  localparam logic [7:0]  LETTER_A      = 8'h41;
  localparam logic [7:0]  LETTER_B      = 8'h42;
  localparam logic [15:0] DIGIT_BASE    = 16'd48;
  localparam logic [15:0] RESET_COMPARE = 16'd1000;
  localparam logic [15:0] RESET_PERIOD  = 16'd20000;
  localparam logic [15:0] WEIGHT_1000   = 16'd1000;
  localparam logic [15:0] WEIGHT_100    = 16'd100;
  localparam logic [15:0] WEIGHT_10     = 16'd10;
  localparam logic [15:0] WEIGHT_1      = 16'd1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REG_PERIOD = 1'b0;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_LETTER = 3'd1,
    PH_DIG0   = 3'd2,
    PH_DIG1   = 3'd3,
    PH_DIG2   = 3'd4,
    PH_DIG3   = 3'd5
  } phase_e;

  typedef struct packed {
    logic        step;
    logic [15:0] period;
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
  } pwm_ctl_t;

  typedef struct packed {
    logic pulse_a;
    logic pulse_b;
  } pwm_pulse_t;

endpackage
`default_nettype wire

@@ rtl/ssc_pwm_timer.sv @@
`default_nettype none
module ssc_pwm_timer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssc_pkg::pwm_ctl_t ctl_i,
  output ssc_pkg::pwm_pulse_t    pulse_o
);
  import ssc_pkg::*;

  logic [15:0] count_q, count_d;
  logic        down_q, down_d;
  logic [15:0] act_a_q, act_a_d;
  logic [15:0] act_b_q, act_b_d;
  logic [15:0] count_up;

  always_comb begin
    count_d  = count_q;
    down_d   = down_q;
    act_a_d  = act_a_q;
    act_b_d  = act_b_q;
    count_up = (count_q < ctl_i.period) ? count_q + 16'd1 : ctl_i.period;
    if (ctl_i.step) begin
      if (!down_q) begin
        count_d = count_up;
        if (count_up == ctl_i.period) begin
          act_a_d = ctl_i.cmp_a;
          act_b_d = ctl_i.cmp_b;
          down_d  = 1'b1;
        end
      end else begin
        if (count_q != 16'd0) begin
          count_d = count_q - 16'd1;
        end
        if (count_d == 16'd0) begin
          down_d = 1'b0;
        end
      end
    end
  end

  // pulses follow the state after this word
  assign pulse_o.pulse_a = (count_d < act_a_d);
  assign pulse_o.pulse_b = (count_d < act_b_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      down_q  <= 1'b0;
      act_a_q <= RESET_COMPARE;
      act_b_q <= RESET_COMPARE;
    end else begin
      count_q <= count_d;
      down_q  <= down_d;
      act_a_q <= act_a_d;
      act_b_q <= act_b_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/serial_servo_command_pwm_unit.sv @@
// Serial servo command parser with a two-channel phase-correct PWM timer.
// Input channel (in_valid_i/in_ready_o): one word per item, operation_i
// selects a received serial byte (rx_byte_i) or one timer tick. Bytes form
// frames of '#', a servo letter and four digits; the sixth byte reports the
// command and a letter 'A' or 'B' loads that channel's pending compare.
// Ticks step an up/down counter between 0 and pwm_period; pending compares
// go live at the top of the count.
// Output channel (out_valid_o/out_ready_i): exactly one result word per
// input word, held in an output register from the cycle after acceptance.
// Throughput is one word per cycle while the receiver takes the results:
// parser and counter update combinationally between the input ports and the output register.
// A stalled receiver keeps the result word; in_ready_o stays high while the
// output register is empty or being taken in the same cycle.
// Reset clears the parser and counter, sets both compares to 1000 and
// pwm_period to 20000. pwm_period is written over APB at addresses 0 to 3
// while the block is idle, a user rule not enforced; pready is always high.
`default_nettype none
module serial_servo_command_pwm_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             pulse_a_o,
  output logic             pulse_b_o,
  output logic             command_done_o,
  output logic [7:0]       command_servo_o,
  output logic [15:0]      command_position_o,
  output logic             command_applied_o
);
  import ssc_pkg::*;

  logic [15:0] period_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  letter_q, letter_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] pend_a_q, pend_a_d;
  logic [15:0] pend_b_q, pend_b_d;
  logic        out_valid_q;
  logic        accept;
  logic        is_byte;
  logic [15:0] weight;
  logic [15:0] digit;
  logic [15:0] term;
  logic [15:0] sum_next;
  logic        done;
  logic        applied;
  pwm_ctl_t    pwm_ctl;
  pwm_pulse_t  pwm_pulse;

  logic        pulse_a_q, pulse_b_q, done_q, applied_q;
  logic [7:0]  servo_q;
  logic [15:0] pos_q;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PERIOD) ? {16'd0, period_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= RESET_PERIOD;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PERIOD)) begin
      period_q <= pwdata[15:0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_byte    = accept && (operation_i == OP_BYTE);

  // frame parser
  always_comb begin
    unique case (phase_q)
      PH_DIG0: weight = WEIGHT_1000;
      PH_DIG1: weight = WEIGHT_100;
      PH_DIG2: weight = WEIGHT_10;
      default: weight = WEIGHT_1;
    endcase
  end

  assign digit    = {8'd0, rx_byte_i} - DIGIT_BASE;
  assign term     = 16'(digit * weight);
  assign sum_next = (phase_q == PH_DIG0) ? term : sum_q + term;

  always_comb begin
    phase_d  = phase_q;
    letter_d = letter_q;
    sum_d    = sum_q;
    pend_a_d = pend_a_q;
    pend_b_d = pend_b_q;
    done     = 1'b0;
    applied  = 1'b0;
    if (is_byte) begin
      unique case (phase_q)
        PH_LETTER: begin
          letter_d = rx_byte_i;
          phase_d  = PH_DIG0;
        end
        PH_DIG0, PH_DIG1, PH_DIG2: begin
          sum_d   = sum_next;
          phase_d = phase_e'(phase_q + 3'd1);
        end
        PH_DIG3: begin
          done = 1'b1;
          if (letter_q == LETTER_A) begin
            pend_a_d = sum_next;
            applied  = 1'b1;
          end else if (letter_q == LETTER_B) begin
            pend_b_d = sum_next;
            applied  = 1'b1;
          end
          letter_d = '0;
          sum_d    = '0;
          phase_d  = PH_START;
        end
        default: begin
          phase_d = (rx_byte_i == START_BYTE) ? PH_LETTER : PH_START;
        end
      endcase
    end
  end

  assign pwm_ctl.step   = accept && (operation_i == OP_TICK);
  assign pwm_ctl.period = period_q;
  assign pwm_ctl.cmp_a  = pend_a_q;
  assign pwm_ctl.cmp_b  = pend_b_q;

  ssc_pwm_timer u_pwm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (pwm_ctl),
    .pulse_o (pwm_pulse)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      letter_q    <= '0;
      sum_q       <= '0;
      pend_a_q    <= RESET_COMPARE;
      pend_b_q    <= RESET_COMPARE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      letter_q    <= letter_d;
      sum_q       <= sum_d;
      pend_a_q    <= pend_a_d;
      pend_b_q    <= pend_b_d;
      out_valid_q <= accept || (out_valid_q && !out_ready_i);
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pulse_a_q <= pwm_pulse.pulse_a;
      pulse_b_q <= pwm_pulse.pulse_b;
      done_q    <= done;
      servo_q   <= done ? letter_q : 8'd0;
      pos_q     <= done ? sum_next : 16'd0;
      applied_q <= applied;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pulse_a_o          = pulse_a_q;
  assign pulse_b_o          = pulse_b_q;
  assign command_done_o     = done_q;
  assign command_servo_o    = servo_q;
  assign command_position_o = pos_q;
  assign command_applied_o  = applied_q;

endmodule
`default_nettype wire

@@ rtl/ssc_check.sv @@
`default_nettype none
module ssc_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        pulse_a_o,
  input wire logic        pulse_b_o,
  input wire logic        command_done_o,
  input wire logic [7:0]  command_servo_o,
  input wire logic [15:0] command_position_o,
  input wire logic        command_applied_o
);
  import ssc_pkg::*;

  // result word fields are zero unless a command finished
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !command_done_o) |->
      (command_servo_o == 8'd0 && command_position_o == 16'd0 && !command_applied_o))
    else $error("command fields set without a finished command");

  // a compare is loaded exactly for letters A and B
  a_applied_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_done_o) |->
      (command_applied_o ==
       (command_servo_o == LETTER_A || command_servo_o == LETTER_B)))
    else $error("applied flag does not match servo letter");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // a stalled word is held
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(pulse_a_o) && $stable(pulse_b_o) &&
       $stable(command_done_o) && $stable(command_position_o)))
    else $error("stalled result word changed");

endmodule

bind serial_servo_command_pwm_unit ssc_check u_ssc_check (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .pulse_a_o          (pulse_a_o),
  .pulse_b_o          (pulse_b_o),
  .command_done_o     (command_done_o),
  .command_servo_o    (command_servo_o),
  .command_position_o (command_position_o),
  .command_applied_o  (command_applied_o)
);
`default_nettype wire

@@ tb/serial_servo_command_pwm_unit_tb.sv @@
`default_nettype none
module serial_servo_command_pwm_unit_tb;
  import ssc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [2:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};
  // no register decoded here
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  typedef struct packed {
    logic        pulse_a;
    logic        pulse_b;
    logic        done;
    logic [7:0]  servo;
    logic [15:0] position;
    logic        applied;
  } servo_word_t;

  typedef struct packed {
    logic        is_reg;
    logic [2:0]  addr;
    logic        op;
    logic [15:0] data;
    logic        typed;
    servo_word_t word;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic        operation = OP_BYTE;
  logic [7:0]  rx_byte = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic        pulse_a_o;
  logic        pulse_b_o;
  logic        command_done_o;
  logic [7:0]  command_servo_o;
  logic [15:0] command_position_o;
  logic        command_applied_o;

  // predicted state of parser and timer
  logic [15:0] period_q = RESET_PERIOD;
  phase_e      parse_ph = PH_START;
  logic [7:0]  letter_q = '0;
  logic [15:0] pos_sum = '0;
  logic [15:0] pend_a = RESET_COMPARE;
  logic [15:0] pend_b = RESET_COMPARE;
  logic [15:0] live_a = RESET_COMPARE;
  logic [15:0] live_b = RESET_COMPARE;
  logic [15:0] tick_cnt = '0;
  logic        count_down = 1'b0;

  servo_word_t due_words[$];
  plan_row_t   plan[$];
  servo_word_t got_word;
  servo_word_t want_word;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          fail_count = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          commands_seen = 0;
  int          commands_applied = 0;
  int          reg_writes = 0;

  serial_servo_command_pwm_unit u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation),
    .rx_byte_i          (rx_byte),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .pulse_a_o          (pulse_a_o),
    .pulse_b_o          (pulse_b_o),
    .command_done_o     (command_done_o),
    .command_servo_o    (command_servo_o),
    .command_position_o (command_position_o),
    .command_applied_o  (command_applied_o)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic servo_word_t next_servo_word(input logic op, input logic [7:0] b);
    servo_word_t w;
    logic [15:0] weight;
    logic [15:0] term;
    w = '0;
    if (op == OP_TICK) begin
      if (!count_down) begin
        if (tick_cnt < period_q) tick_cnt = tick_cnt + 16'd1;
        else tick_cnt = period_q;
        if (tick_cnt == period_q) begin
          live_a = pend_a;
          live_b = pend_b;
          count_down = 1'b1;
        end
      end else begin
        if (tick_cnt != 16'd0) tick_cnt = tick_cnt - 16'd1;
        if (tick_cnt == 16'd0) count_down = 1'b0;
      end
    end else begin
      case (parse_ph)
        PH_START: begin
          if (b == START_BYTE) parse_ph = PH_LETTER;
        end
        PH_LETTER: begin
          letter_q = b;
          parse_ph = PH_DIG0;
        end
        default: begin
          case (parse_ph)
            PH_DIG0: weight = WEIGHT_1000;
            PH_DIG1: weight = WEIGHT_100;
            PH_DIG2: weight = WEIGHT_10;
            default: weight = WEIGHT_1;
          endcase
          term = ({8'h00, b} - DIGIT_BASE) * weight;
          pos_sum = (parse_ph == PH_DIG0) ? term : pos_sum + term;
          if (parse_ph == PH_DIG3) begin
            w.done = 1'b1;
            w.servo = letter_q;
            w.position = pos_sum;
            if (letter_q == LETTER_A) begin
              pend_a = pos_sum;
              w.applied = 1'b1;
            end else if (letter_q == LETTER_B) begin
              pend_b = pos_sum;
              w.applied = 1'b1;
            end
            letter_q = '0;
            pos_sum = '0;
            parse_ph = PH_START;
          end else begin
            parse_ph = phase_e'(parse_ph + 3'd1);
          end
        end
      endcase
    end
    w.pulse_a = (tick_cnt < live_a);
    w.pulse_b = (tick_cnt < live_b);
    return w;
  endfunction

  function automatic servo_word_t make_word(input logic pa, input logic pb, input logic dn,
                                            input logic [7:0] servo, input logic [15:0] pos,
                                            input logic app);
    servo_word_t w;
    w.pulse_a = pa;
    w.pulse_b = pb;
    w.done = dn;
    w.servo = servo;
    w.position = pos;
    w.applied = app;
    return w;
  endfunction

  function automatic plan_row_t item_row(input logic op, input logic [7:0] b);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.data = {8'h00, b};
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic op, input logic [7:0] b,
                                            input servo_word_t w);
    plan_row_t r;
    r = item_row(op, b);
    r.typed = 1'b1;
    r.word = w;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] addr, input logic [15:0] value);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.addr = addr;
    r.data = value;
    return r;
  endfunction

  function automatic logic [7:0] digit_byte(input int value, input int place);
    int divisor;
    divisor = 10 ** (3 - place);
    return DIGIT_BASE[7:0] + 8'((value / divisor) % 10);
  endfunction

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      got_word = make_word(pulse_a_o, pulse_b_o, command_done_o, command_servo_o,
                           command_position_o, command_applied_o);
      if (due_words.size() == 0) begin
        fail_count++;
        $display("%0t: result word with none expected, got %h", $time, got_word);
      end else begin
        want_word = due_words.pop_front();
        words_checked++;
        if (got_word.done === 1'b1) commands_seen++;
        if (got_word.applied === 1'b1) commands_applied++;
        if (got_word.pulse_a !== want_word.pulse_a)
          report_field("pulse_a", 16'(want_word.pulse_a), 16'(got_word.pulse_a));
        if (got_word.pulse_b !== want_word.pulse_b)
          report_field("pulse_b", 16'(want_word.pulse_b), 16'(got_word.pulse_b));
        if (got_word.done !== want_word.done)
          report_field("command_done", 16'(want_word.done), 16'(got_word.done));
        if (got_word.servo !== want_word.servo)
          report_field("command_servo", 16'(want_word.servo), 16'(got_word.servo));
        if (got_word.position !== want_word.position)
          report_field("command_position", want_word.position, got_word.position);
        if (got_word.applied !== want_word.applied)
          report_field("command_applied", 16'(want_word.applied), 16'(got_word.applied));
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] b, input logic typed,
                           input servo_word_t typed_word);
    servo_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    rx_byte = b;
    do @(posedge clk); while (!in_ready_o);
    w = next_servo_word(op, b);
    due_words.push_back(typed ? typed_word : w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    do @(negedge clk); while (due_words.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    drain_results();
    repeat (2) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == PERIOD_ADDR) period_q = value;
    reg_writes++;
    // read back through the same port
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == PERIOD_ADDR && prdata !== 32'(period_q)) begin
      fail_count++;
      $display("%0t: pwm_period read back, expected %0h, got %0h", $time, period_q, prdata);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_phase(input int n_words);
    int first;
    int pick;
    int k;
    int target;
    logic [7:0] letter;
    first = words_sent;
    while (words_sent - first < n_words) begin
      if ($urandom_range(49) == 0) drain_results();
      pick = $urandom_range(99);
      if (pick < 55) begin
        repeat ($urandom_range(1, 12)) send_word(OP_TICK, 8'($urandom), 1'b0, '0);
      end else if (pick < 85) begin
        k = $urandom_range(99);
        letter = (k < 45) ? LETTER_A : (k < 90) ? LETTER_B : 8'($urandom);
        if ($urandom_range(7) == 0) target = $urandom_range(9999);
        else target = $urandom_range(period_q + period_q / 4 + 2);
        if (target > 9999) target = 9999;
        send_word(OP_BYTE, START_BYTE, 1'b0, '0);
        send_word(OP_BYTE, letter, 1'b0, '0);
        for (k = 0; k < 4; k++) begin
          if ($urandom_range(9) == 0) send_word(OP_BYTE, 8'($urandom), 1'b0, '0);
          else send_word(OP_BYTE, digit_byte(target, k), 1'b0, '0);
        end
      end else if (pick < 93) begin
        send_word(OP_BYTE, START_BYTE, 1'b0, '0);
        repeat ($urandom_range(0, 3)) send_word(OP_BYTE, 8'($urandom), 1'b0, '0);
      end else begin
        send_word(OP_BYTE, 8'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin
    #(4 * LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int k;
    int p;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    plan.push_back(checked_row(OP_TICK, 8'h00, make_word(1'b1, 1'b1, 1'b0, '0, '0, 1'b0)));
    // stray byte outside a frame
    plan.push_back(checked_row(OP_BYTE, 8'h78, make_word(1'b1, 1'b1, 1'b0, '0, '0, 1'b0)));
    plan.push_back(item_row(OP_BYTE, START_BYTE));
    plan.push_back(item_row(OP_BYTE, LETTER_A));
    for (k = 0; k < 3; k++) plan.push_back(item_row(OP_BYTE, digit_byte(2, k)));
    plan.push_back(checked_row(OP_BYTE, digit_byte(2, 3),
                               make_word(1'b1, 1'b1, 1'b1, LETTER_A, 16'd2, 1'b1)));
    // start byte as letter, digits out of range
    plan.push_back(item_row(OP_BYTE, START_BYTE));
    plan.push_back(item_row(OP_BYTE, START_BYTE));
    plan.push_back(item_row(OP_BYTE, 8'hFF));
    plan.push_back(item_row(OP_BYTE, 8'h00));
    plan.push_back(item_row(OP_BYTE, digit_byte(9, 3)));
    plan.push_back(item_row(OP_BYTE, digit_byte(9, 3)));
    plan.push_back(reg_row(PERIOD_ADDR, 16'd3));
    repeat (3) plan.push_back(item_row(OP_TICK, 8'h00));
    // counter above top on the way down
    plan.push_back(reg_row(PERIOD_ADDR, 16'd1));
    repeat (2) plan.push_back(item_row(OP_TICK, 8'hFF));
    plan.push_back(reg_row(PERIOD_ADDR, 16'd4));
    repeat (2) plan.push_back(item_row(OP_TICK, 8'h00));
    // counter already at top on the way up
    plan.push_back(reg_row(PERIOD_ADDR, 16'd1));
    plan.push_back(item_row(OP_TICK, 8'h00));
    plan.push_back(reg_row(PERIOD_ADDR, 16'd0));
    repeat (3) plan.push_back(item_row(OP_TICK, 8'h00));
    plan.push_back(reg_row(SPARE_ADDR, 16'h1234));

    send_idle_pct = 18;
    recv_idle_pct = 59;
    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].addr, plan[i].data);
      else send_word(plan[i].op, plan[i].data[7:0], plan[i].typed, plan[i].word);
    end

    for (p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: write_reg(PERIOD_ADDR, 16'($urandom_range(2, 40)));
        1: write_reg(PERIOD_ADDR, 16'd1);
        2: write_reg(PERIOD_ADDR, 16'($urandom_range(50, 300)));
        3: write_reg(PERIOD_ADDR, 16'hFFFF);
        4: write_reg(PERIOD_ADDR, 16'($urandom_range(2, 40)));
        default: write_reg(PERIOD_ADDR, 16'($urandom_range(5, 120)));
      endcase
      run_phase(p == 3 ? 60 : 195);
    end

    drain_results();
    repeat (4) @(negedge clk);
    $display("%0d words sent, %0d results checked, %0d register writes",
             words_sent, words_checked, reg_writes);
    $display("%0d commands completed, %0d loaded a compare", commands_seen, commands_applied);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
